### hdl/assert_macros.svh
// Assertion macros used by the console engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset
`define TCC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle forces a consequence in the next
`define TCC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TCC_ASSERT(name, clk, rst, prop, msg)
`define TCC_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif
`endif

### hdl/tcc_pkg.sv
// Shared types and constants of the text console cursor engine
package tcc_pkg;

   // Fixed field widths
   localparam int ROW_W = 6;
   localparam int COL_W = 7;
   localparam int LIN_W = ROW_W + COL_W;
   localparam int CSR_AW = 3;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_BLANK = 8'd32;
   localparam logic [7:0] TAB_MASK = ~8'd3;

   // Attribute of the blanks written after reset
   localparam logic [7:0] RESET_FILL = 8'd15;

   // Register map: index bit of the word address
   localparam logic REG_FILL_COLOR = 1'b0;

   // Command codes
   typedef enum logic [2:0] {
      K_PUT   = 3'd0,
      K_BACK  = 3'd1,
      K_CLEAR = 3'd2,
      K_SET   = 3'd3,
      K_READ  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        ch;
      logic [7:0]        color;
      logic signed [7:0] row;
      logic signed [7:0] col;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] pos_row;
      logic [COL_W-1:0] pos_col;
      logic [7:0]       read_char;
      logic [7:0]       read_color;
   } rsp_type;

   // One screen cell: attribute in the high byte
   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] chr;
   } cell_type;

   typedef struct packed {
      logic             en;
      logic [LIN_W-1:0] addr;
      cell_type         data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [LIN_W-1:0] addr;
   } ram_rd_type;

endpackage

### hdl/text_console_cursor_engine_top.sv
// Flow: each command passes through the address, execute and done states, and the result beat
// is registered from done; an on-screen cell read adds a read-data state. A new command is
// taken only in idle, after the last result was handed on. Clear, and a put or line feed that
// scrolls, sweep the store one cell per cycle.
// Reset: synchronous; afterwards a blanking sweep over all ROWS*COLUMNS cells (2000 by default)
// stalls the request side while register writes are still taken.
module text_console_cursor_engine_top
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [7:0] fill_color;
   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   cell_type   ram_rdata;

   tcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .fill_color(fill_color)
   );

   tcc_screen_ram #(
      .DEPTH(ROWS * COLUMNS)
   ) u_ram (
      .clock(clock),
      .wr   (ram_wr),
      .rd   (ram_rd),
      .rdata(ram_rdata)
   );

   tcc_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .fill_color(fill_color),
      .ram_wr    (ram_wr),
      .ram_rd    (ram_rd),
      .ram_rdata (ram_rdata)
   );

endmodule

### hdl/tcc_csr.sv
// APB register block holding the fill attribute
module tcc_csr
   import tcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [7:0]        fill_color
);

   logic [7:0] fill_color_ff;
   logic [7:0] fill_color_in;
   logic       wr_hit;

   // Write decode on the access phase
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_FILL_COLOR);

   always_comb begin
      fill_color_in = fill_color_ff;
      if (wr_hit) begin
         fill_color_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= RESET_FILL;
      end else begin
         fill_color_ff <= fill_color_in;
      end
   end

   // Read mux, unused low address bits ignored
   assign prdata = (paddr[2] == REG_FILL_COLOR) ? {24'd0, fill_color_ff} : 32'd0;
   assign pready = 1'b1;
   assign fill_color = fill_color_ff;

endmodule

### hdl/tcc_addr_unit.sv
// Shared cell address unit: row * COLUMNS + col, registered
module tcc_addr_unit
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80
)
(
   input  logic             clock,
   input  logic [ROW_W-1:0] row,
   input  logic [COL_W-1:0] col,
   output logic [LIN_W-1:0] addr
);

   logic [LIN_W-1:0] addr_ff;
   logic [LIN_W-1:0] addr_in;

   // Small multiply-add, result registered
   assign addr_in = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr = addr_ff;

endmodule

### hdl/tcc_screen_ram.sv
// Screen cell store: one write port, one registered read port
module tcc_screen_ram
   import tcc_pkg::*;
#(
   parameter int DEPTH = 2000
)
(
   input  logic       clock,
   input  ram_wr_type wr,
   input  ram_rd_type rd,
   output cell_type   rdata
);

   localparam int AW = $clog2(DEPTH);

   cell_type mem [DEPTH];
   cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/tcc_engine.sv
// Command sequencer: cursor logic, fill and scroll sweeps, result register
`include "assert_macros.svh"
module tcc_engine
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic [7:0] fill_color,
   output ram_wr_type ram_wr,
   output ram_rd_type ram_rd,
   input  cell_type   ram_rdata
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam logic [LIN_W-1:0] LAST_CELL = LIN_W'(CELLS - 1);
   localparam logic [LIN_W-1:0] LAST_BASE = LIN_W'(CELLS - COLUMNS);
   localparam logic [LIN_W-1:0] ROW_STEP  = LIN_W'(COLUMNS);
   localparam logic [ROW_W:0]   ROWS_C    = (ROW_W + 1)'(ROWS);
   localparam logic [COL_W:0]   COLS_C    = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_ADDR, S_EXEC, S_RDATA, S_SCROLL, S_BLANK, S_CLEAR, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [LIN_W-1:0] i_ff, i_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       ch_ff, ch_in;
   logic [7:0]       color_ff, color_in;
   logic [ROW_W-1:0] op_row_ff, op_row_in;
   logic [COL_W-1:0] op_col_ff, op_col_in;
   logic             flag_ff, flag_in;
   logic             pend_ff, pend_in;
   logic [LIN_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]       res_char_ff, res_char_in;
   logic [7:0]       res_color_ff, res_color_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [LIN_W-1:0] addr_q;
   logic [ROW_W:0]   row_inc;
   logic [COL_W:0]   col_inc;
   logic [COL_W:0]   tab_col;
   logic             row_over;
   logic             do_nl;

   // Shared address unit, fed from the operand registers
   tcc_addr_unit #(
      .COLUMNS(COLUMNS)
   ) u_addr (
      .clock(clock),
      .row  (op_row_ff),
      .col  (op_col_ff),
      .addr (addr_q)
   );

   assign accept  = req_valid && !req_stall;
   assign row_inc = {1'b0, cur_row_ff} + (ROW_W + 1)'(1);
   assign col_inc = {1'b0, cur_col_ff} + (COL_W + 1)'(1);
   assign tab_col = ({1'b0, cur_col_ff} + (COL_W + 1)'(4)) & TAB_MASK;
   assign row_over = (row_inc >= ROWS_C);

   // Next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      kind_in      = kind_ff;
      ch_in        = ch_ff;
      color_in     = color_ff;
      op_row_in    = op_row_ff;
      op_col_in    = op_col_ff;
      flag_in      = flag_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_char_in  = res_char_ff;
      res_color_in = res_color_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      do_nl        = 1'b0;
      ram_wr       = '0;
      ram_rd       = '0;

      unique case (state_ff)
         // Blank sweep after reset, reset attribute
         S_INIT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = i_ff;
            ram_wr.data = '{attr: RESET_FILL, chr: CH_BLANK};
            i_in        = i_ff + LIN_W'(1);
            if (i_ff == LAST_CELL) begin
               i_in     = '0;
               state_in = S_IDLE;
            end
         end

         // Take a command and set up its operands
         S_IDLE: begin
            if (accept) begin
               kind_in      = kind_type'(req_data.kind);
               ch_in        = req_data.ch;
               color_in     = req_data.color;
               res_char_in  = '0;
               res_color_in = '0;
               op_row_in    = cur_row_ff;
               op_col_in    = cur_col_ff;
               flag_in      = 1'b0;
               state_in     = S_ADDR;
               unique case (kind_type'(req_data.kind))
                  K_BACK: begin
                     if (cur_col_ff != '0) begin
                        op_col_in = cur_col_ff - COL_W'(1);
                        flag_in   = 1'b1;
                     end else if (cur_row_ff != '0) begin
                        op_row_in = cur_row_ff - ROW_W'(1);
                        op_col_in = LAST_COL;
                        flag_in   = 1'b1;
                     end
                  end
                  K_SET: begin
                     priority if (req_data.row[7]) begin
                        op_row_in = '0;
                     end else if ({1'b0, req_data.row[6:0]} >= (ROW_W + 2)'(ROWS_C)) begin
                        op_row_in = LAST_ROW;
                     end else begin
                        op_row_in = req_data.row[ROW_W-1:0];
                     end
                     priority if (req_data.col[7]) begin
                        op_col_in = '0;
                     end else if ({1'b0, req_data.col[6:0]} >= COLS_C) begin
                        op_col_in = LAST_COL;
                     end else begin
                        op_col_in = req_data.col[COL_W-1:0];
                     end
                  end
                  K_READ: begin
                     op_row_in = req_data.row[ROW_W-1:0];
                     op_col_in = req_data.col[COL_W-1:0];
                     flag_in   = !req_data.row[7] && !req_data.col[7]
                                 && ({1'b0, req_data.row[6:0]} < (ROW_W + 2)'(ROWS_C))
                                 && ({1'b0, req_data.col[6:0]} < COLS_C);
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Address unit settles
         S_ADDR: begin
            state_in = S_EXEC;
         end

         // Carry out the command
         S_EXEC: begin
            state_in = S_DONE;
            unique case (kind_ff)
               K_PUT: begin
                  priority if (ch_ff == CH_LF) begin
                     do_nl = 1'b1;
                  end else if (ch_ff == CH_CR) begin
                     cur_col_in = '0;
                  end else if (ch_ff == CH_TAB) begin
                     if (tab_col >= COLS_C) begin
                        do_nl = 1'b1;
                     end else begin
                        cur_col_in = tab_col[COL_W-1:0];
                     end
                  end else begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = addr_q;
                     ram_wr.data = '{attr: color_ff, chr: ch_ff};
                     if (col_inc >= COLS_C) begin
                        do_nl = 1'b1;
                     end else begin
                        cur_col_in = col_inc[COL_W-1:0];
                     end
                  end
                  // Line feed: next row, or scroll at the bottom
                  if (do_nl) begin
                     cur_col_in = '0;
                     if (row_over) begin
                        i_in     = '0;
                        state_in = S_SCROLL;
                     end else begin
                        cur_row_in = row_inc[ROW_W-1:0];
                     end
                  end
               end
               K_BACK: begin
                  if (flag_ff) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = addr_q;
                     ram_wr.data = '{attr: fill_color, chr: CH_BLANK};
                     cur_row_in  = op_row_ff;
                     cur_col_in  = op_col_ff;
                  end
               end
               K_CLEAR: begin
                  i_in       = '0;
                  cur_row_in = '0;
                  cur_col_in = '0;
                  state_in   = S_CLEAR;
               end
               K_SET: begin
                  cur_row_in = op_row_ff;
                  cur_col_in = op_col_ff;
               end
               K_READ: begin
                  if (flag_ff) begin
                     ram_rd.en   = 1'b1;
                     ram_rd.addr = addr_q;
                     state_in    = S_RDATA;
                  end
               end
               default: begin
               end
            endcase
         end

         // Read data is back from the store
         S_RDATA: begin
            res_char_in  = ram_rdata.chr;
            res_color_in = ram_rdata.attr;
            state_in     = S_DONE;
         end

         // Copy each cell one row up: read ahead, write from the registered read data
         S_SCROLL: begin
            ram_wr.en   = pend_ff;
            ram_wr.addr = pend_addr_ff;
            ram_wr.data = ram_rdata;
            if (i_ff < LAST_BASE) begin
               ram_rd.en    = 1'b1;
               ram_rd.addr  = i_ff + ROW_STEP;
               pend_in      = 1'b1;
               pend_addr_in = i_ff;
               i_in         = i_ff + LIN_W'(1);
            end else begin
               state_in = S_BLANK;
            end
         end

         // Blank the bottom row
         S_BLANK: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = i_ff;
            ram_wr.data = '{attr: fill_color, chr: CH_BLANK};
            i_in        = i_ff + LIN_W'(1);
            if (i_ff == LAST_CELL) begin
               i_in       = '0;
               cur_row_in = LAST_ROW;
               cur_col_in = '0;
               state_in   = S_DONE;
            end
         end

         // Blank the whole screen in the fill attribute
         S_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = i_ff;
            ram_wr.data = '{attr: fill_color, chr: CH_BLANK};
            i_in        = i_ff + LIN_W'(1);
            if (i_ff == LAST_CELL) begin
               i_in     = '0;
               state_in = S_DONE;
            end
         end

         // Hand the result beat to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.pos_row    = cur_row_ff;
               rsp_in.pos_col    = cur_col_ff;
               rsp_in.read_char  = res_char_ff;
               rsp_in.read_color = res_color_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         i_ff         <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      ch_ff        <= ch_in;
      color_ff     <= color_in;
      op_row_ff    <= op_row_in;
      op_col_ff    <= op_col_in;
      flag_ff      <= flag_in;
      pend_addr_ff <= pend_addr_in;
      res_char_ff  <= res_char_in;
      res_color_ff <= res_color_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `TCC_ASSERT(a_row_range, clock, reset, {1'b0, cur_row_ff} < ROWS_C, "cursor row off screen")
   `TCC_ASSERT(a_col_range, clock, reset, {1'b0, cur_col_ff} < COLS_C, "cursor col off screen")
   `TCC_ASSERT(a_wr_range, clock, reset, !ram_wr.en || (ram_wr.addr <= LAST_CELL), "cell write out of range")
   `TCC_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE, "result beat outside done")
   `TCC_ASSERT_NEXT(a_scroll_end, clock, reset, state_ff == S_SCROLL && i_ff >= LAST_BASE, state_ff == S_BLANK && !pend_ff, "scroll copy not drained")

endmodule

### test/console_checker.sv
// Checker for the text console engine: tracks the screen, predicts every result beat and compares
module console_checker
   import tcc_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   input  logic [31:0]       prdata,
   input  logic              pready,
   output int                error_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = ROWS * COLUMNS;
   localparam logic [CSR_AW-1:0] FILL_ADDR = {REG_FILL_COLOR, 2'b00};

   // Shadow copy of the screen, cursor and fill attribute
   cell_type   screen [CELLS];
   int         cur_row;
   int         cur_col;
   logic [7:0] fill_attr;

   // Cursor reports and cell reads still owed by the block, oldest first
   rsp_type    owed_reports [$];
   int         errors = 0;
   int         beats_seen = 0;

   assign error_count = errors;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH beat %0d %s: got %0d expected %0d",
               $realtime, beats_seen, what, got, want);
      errors++;
   endtask

   function automatic cell_type blank_cell();
      cell_type c;
      c.attr = fill_attr;
      c.chr  = CH_BLANK;
      return c;
   endfunction

   function automatic void blank_screen();
      foreach (screen[i]) screen[i] = blank_cell();
   endfunction

   // Move rows up by one, blank the bottom row, park the cursor on it
   function automatic void scroll_screen();
      for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) screen[(ROWS - 1) * COLUMNS + c] = blank_cell();
      cur_row = ROWS - 1;
      cur_col = 0;
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) scroll_screen();
   endfunction

   function automatic void put_char(input logic [7:0] chr, input logic [7:0] attr);
      logic [7:0] tab_col;
      if (chr == CH_LF) begin
         line_feed();
      end else if (chr == CH_CR) begin
         cur_col = 0;
      end else if (chr == CH_TAB) begin
         tab_col = 8'(cur_col + 4) & TAB_MASK;
         cur_col = int'(tab_col);
         if (cur_col >= COLUMNS) line_feed();
      end else begin
         screen[cur_row * COLUMNS + cur_col].chr  = chr;
         screen[cur_row * COLUMNS + cur_col].attr = attr;
         cur_col++;
         if (cur_col >= COLUMNS) line_feed();
      end
   endfunction

   // Step back, crossing to the end of the previous row; stop at origin
   function automatic void back_space();
      if (cur_col == 0) begin
         if (cur_row == 0) return;
         cur_row--;
         cur_col = COLUMNS;
      end
      cur_col--;
      screen[cur_row * COLUMNS + cur_col] = blank_cell();
   endfunction

   function automatic int clamp(input int v, input int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
   endfunction

   // Apply one command to the shadow state and build the beat it should produce
   function automatic rsp_type apply_command(input req_type cmd);
      rsp_type r;
      int      tr;
      int      tc;
      r  = '0;
      tr = $signed(cmd.row);
      tc = $signed(cmd.col);
      case (cmd.kind)
         K_PUT:   put_char(cmd.ch, cmd.color);
         K_BACK:  back_space();
         K_CLEAR: begin
            blank_screen();
            cur_row = 0;
            cur_col = 0;
         end
         K_SET: begin
            cur_row = clamp(tr, ROWS);
            cur_col = clamp(tc, COLUMNS);
         end
         K_READ: begin
            if (tr >= 0 && tr < ROWS && tc >= 0 && tc < COLUMNS) begin
               r.read_char  = screen[tr * COLUMNS + tc].chr;
               r.read_color = screen[tr * COLUMNS + tc].attr;
            end
         end
         default: ;
      endcase
      r.pos_row = ROW_W'(cur_row);
      r.pos_col = COL_W'(cur_col);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill_attr = RESET_FILL;
         blank_screen();
         cur_row = 0;
         cur_col = 0;
         owed_reports.delete();
      end else begin
         // Result beat: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (owed_reports.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_data), 0);
            end else begin
               want = owed_reports.pop_front();
               if (rsp_data.pos_row != want.pos_row)
                  report_mismatch("pos_row", rsp_data.pos_row, want.pos_row);
               if (rsp_data.pos_col != want.pos_col)
                  report_mismatch("pos_col", rsp_data.pos_col, want.pos_col);
               if (rsp_data.read_char != want.read_char)
                  report_mismatch("read_char", rsp_data.read_char, want.read_char);
               if (rsp_data.read_color != want.read_color)
                  report_mismatch("read_color", rsp_data.read_color, want.read_color);
            end
         end
         // Command beat: predict
         if (req_valid && !req_stall) owed_reports.push_back(apply_command(req_data));
         // Register access phase
         if (psel && penable && pready && paddr == FILL_ADDR) begin
            if (pwrite) fill_attr = pwdata[7:0];
            else if (prdata != 32'(fill_attr))
               report_mismatch("fill_color readback", int'(prdata), int'(fill_attr));
         end
      end
      pending = owed_reports.size();
   end

endmodule

### test/testbench.sv
// Top of the console engine testbench: clock, reset, command stimulus, receiver and verdict
module testbench;
   import tcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [2:0] K_SPARE_LO = 3'd5;
   localparam logic [2:0] K_SPARE_HI = 3'd7;
   localparam logic [CSR_AW-1:0] FILL_ADDR = {REG_FILL_COLOR, 2'b00};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int   error_count;
   int   pending;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   kind_count [8];
   int   idle_cycles = 0;
   int   fill_mid;
   logic hold_toggle = 1'b0;
   logic hold_seen;
   int   hold_left;

   always #5 clock = ~clock;

   text_console_cursor_engine_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .error_count (error_count),
      .pending     (pending)
   );

   // Watchdog: cycles without any beat or register access
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic req_type make_cmd(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic [7:0] color, input int row, input int col);
      req_type cmd;
      cmd.kind  = kind;
      cmd.ch    = ch;
      cmd.color = color;
      cmd.row   = 8'(row);
      cmd.col   = 8'(col);
      return cmd;
   endfunction

   // Coordinate mostly on screen, sometimes at the edges, sometimes any byte
   function automatic logic [7:0] pick_coord(input int lim);
      int p;
      p = $urandom_range(99);
      if (p < 70) return 8'($urandom_range(lim - 1));
      if (p < 85) begin
         case ($urandom_range(3))
            0: return 8'(lim - 1);
            1: return 8'(lim);
            2: return 8'(-1);
            default: return 8'(0);
         endcase
      end
      return 8'($urandom);
   endfunction

   function automatic req_type random_command();
      req_type cmd;
      int      p;
      int      q;
      cmd.kind  = K_PUT;
      cmd.ch    = 8'($urandom);
      cmd.color = 8'($urandom);
      cmd.row   = 8'($urandom);
      cmd.col   = 8'($urandom);
      p = $urandom_range(99);
      if (p < 55) begin
         q = $urandom_range(99);
         if (q < 10) cmd.ch = CH_LF;
         else if (q < 16) cmd.ch = CH_CR;
         else if (q < 24) cmd.ch = CH_TAB;
      end else if (p < 63) begin
         cmd.kind = K_BACK;
      end else if (p < 64) begin
         cmd.kind = K_CLEAR;
      end else if (p < 74) begin
         cmd.kind = K_SET;
         cmd.row  = pick_coord(ROWS);
         cmd.col  = pick_coord(COLUMNS);
      end else if (p < 94) begin
         cmd.kind = K_READ;
         cmd.row  = pick_coord(ROWS);
         cmd.col  = pick_coord(COLUMNS);
      end else begin
         cmd.kind = 3'($urandom_range(K_SPARE_HI, K_SPARE_LO));
      end
      return cmd;
   endfunction

   // Offer one command beat; called and returns at a falling edge
   task automatic send_cmd(input req_type cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      kind_count[cmd.kind]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every result beat is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= FILL_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Set the fill attribute once the block has settled, then read it back
   task automatic set_fill(input logic [7:0] value);
      repeat (8) @(negedge clock);
      csr_access(1'b1, 32'(value));
      csr_access(1'b0, 32'd0);
   endtask

   // Type a short word somewhere on screen and read every cell of it back
   task automatic type_and_verify(output int used);
      int         r;
      int         c;
      int         n;
      logic [7:0] chr;
      n = $urandom_range(6, 1);
      r = $urandom_range(ROWS - 1);
      c = $urandom_range(COLUMNS - 1 - n);
      send_cmd(make_cmd(K_SET, 8'($urandom), 8'($urandom), r, c));
      for (int i = 0; i < n; i++) begin
         chr = 8'($urandom);
         if (chr == CH_LF || chr == CH_CR || chr == CH_TAB) chr = chr ^ 8'h40;
         send_cmd(make_cmd(K_PUT, chr, 8'($urandom), $urandom, $urandom));
      end
      for (int i = 0; i < n; i++)
         send_cmd(make_cmd(K_READ, 8'($urandom), 8'($urandom), r, c + i));
      used = 2 * n + 1;
   endtask

   task automatic run_random(input int count);
      int left;
      int used;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 15) begin
            type_and_verify(used);
            left -= used;
         end else begin
            send_cmd(random_command());
            left--;
         end
      end
   endtask

   task automatic run_directed();
      // Reset contents and reads off the screen
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, 0, 0));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, ROWS - 1, COLUMNS - 1));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, -1, 0));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, 0, COLUMNS));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, ROWS, 0));
      send_cmd(make_cmd(K_READ, 8'hFF, 8'hFF, 127, 127));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, -128, -128));
      // Plain characters at the byte extremes
      send_cmd(make_cmd(K_PUT, 8'h41, 8'hFF, 0, 0));
      send_cmd(make_cmd(K_PUT, 8'h00, 8'h00, 0, 0));
      send_cmd(make_cmd(K_PUT, 8'hFF, 8'h5A, -1, -1));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, 0, 1));
      // Tab, return, newline
      send_cmd(make_cmd(K_PUT, CH_TAB, 8'h00, 0, 0));
      send_cmd(make_cmd(K_PUT, CH_CR, 8'h00, 0, 0));
      send_cmd(make_cmd(K_PUT, CH_LF, 8'h00, 0, 0));
      // Clamp low, backspace at origin
      send_cmd(make_cmd(K_SET, 8'h00, 8'h00, -128, -128));
      send_cmd(make_cmd(K_BACK, 8'h00, 8'h00, 0, 0));
      // Clamp high, then a put that wraps past the last row and scrolls
      send_cmd(make_cmd(K_SET, 8'h00, 8'h00, 127, 127));
      send_cmd(make_cmd(K_PUT, 8'h7E, 8'hA5, 0, 0));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, ROWS - 2, COLUMNS - 1));
      // Backspace from column zero crosses to the row above
      send_cmd(make_cmd(K_SET, 8'h00, 8'h00, 3, 0));
      send_cmd(make_cmd(K_BACK, 8'h00, 8'h00, 0, 0));
      // Tab off the end of the last row scrolls
      send_cmd(make_cmd(K_SET, 8'h00, 8'h00, ROWS - 1, COLUMNS - 4));
      send_cmd(make_cmd(K_PUT, CH_TAB, 8'h00, 0, 0));
      // Unused codes, then clear
      for (int k = K_SPARE_LO; k <= K_SPARE_HI; k++)
         send_cmd(make_cmd(3'(k), 8'hFF, 8'hFF, 127, 127));
      send_cmd(make_cmd(K_CLEAR, 8'h00, 8'h00, 0, 0));
      send_cmd(make_cmd(K_READ, 8'h00, 8'h00, 0, 0));
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      fill_mid  = $urandom_range(254, 1);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands with the reset fill attribute
      run_directed();
      drain();

      // Sender idles often, receiver stalls most of the time
      set_fill(8'h00);
      send_idle_pct = 36;
      recv_idle_pct = 85;
      run_random(140);
      drain();

      // Roles swapped
      set_fill(8'hFF);
      send_idle_pct = 85;
      recv_idle_pct = 36;
      run_random(140);
      drain();

      // Long receiver hold-off while commands keep coming, then full rate
      set_fill(8'(fill_mid));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      for (int i = 0; i < 30; i++) send_cmd(random_command());
      drain();
      run_random(120);
      drain();

      repeat (20) @(posedge clock);
      $display("Covered %0d puts, %0d backspaces, %0d clears, %0d cursor sets, %0d reads, %0d spare",
               kind_count[K_PUT], kind_count[K_BACK], kind_count[K_CLEAR], kind_count[K_SET],
               kind_count[K_READ], kind_count[5] + kind_count[6] + kind_count[7]);
      $display("Fill attribute 15, 0, 255 and %0d, with both sides stalling and one long hold-off",
               fill_mid);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
